[hw/rtl/msl_pkg.sv]
// msl_pkg: shared constants, command codes and control types for the
// median of two sorted lists block; no dependencies
`timescale 1ns / 1ps

package msl_pkg;

    // list capacity and derived widths
    localparam int MAX_LEN = 1024;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int TOT_W   = CNT_W + 1;
    localparam int DATA_W  = 32;
    localparam int RES_W   = DATA_W + 1;
    localparam int CMD_W   = 2;

    // input word command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_FIRST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_SECOND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE     = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load_first;
        logic load_second;
        logic start;
        logic step;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic set_empty;
        logic last_step;
    } t_stat;

endpackage

[hw/rtl/median_of_two_sorted_lists.sv]
// median_of_two_sorted_lists: top level joining controller and datapath
// depends on msl_pkg, msl_ctrl and msl_dp
//
// Usage: the input channel (i_valid, o_stall, i_cmd, i_value) takes one
// word per cycle while o_stall is low. Command 0 appends i_value to the
// first list, command 1 to the second; each list holds up to MAX_LEN
// signed values, which the user must load ascending (the block does not
// check this); further loads are dropped and flagged. Command 2 computes
// twice the median of the combined list and then empties both lists;
// command 3 is ignored. The output channel (o_valid, i_stall) returns one
// word per compute: o_twice_median, o_empty_set and o_dropped. A compute
// walks the two memories one merge step per cycle, and the result shows
// the cycle after the last step; an empty set gives its result the cycle
// after the compute is taken. The walk rate is set by the single read
// port of each list memory. The input side stalls during the walk and
// while a result waits under i_stall; the cycle the result is taken, a
// new word may be accepted. Synchronous reset empties both lists and
// clears the flag; memory contents are left as they are.
`timescale 1ns / 1ps

module median_of_two_sorted_lists (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [msl_pkg::CMD_W-1:0]         i_cmd,
    input  logic signed [msl_pkg::DATA_W-1:0] i_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [msl_pkg::RES_W-1:0]  o_twice_median,
    output logic                              o_empty_set,
    output logic                              o_dropped
);

    import msl_pkg::*;

    t_cmd  w_dp_cmd;
    t_stat w_stat;

    // controller
    msl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_cmd    (i_cmd),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_stat   (w_stat),
        .o_dp_cmd (w_dp_cmd)
    );

    // datapath
    msl_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_dp_cmd       (w_dp_cmd),
        .i_value        (i_value),
        .o_stat         (w_stat),
        .o_twice_median (o_twice_median),
        .o_empty_set    (o_empty_set),
        .o_dropped      (o_dropped)
    );

    // no word is taken while the merge walk runs
    a_walk_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dp_cmd.step |-> o_stall)
        else $error("input accepted during merge walk");

    // an empty set gives a zero result
    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_empty_set) |-> (o_twice_median == '0))
        else $error("empty set with nonzero result");

    // compute on empty lists presents its result the next cycle
    a_empty_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dp_cmd.start && w_stat.set_empty) |=> (o_valid && o_empty_set))
        else $error("empty compute did not present its result");

    // the last walk step always leads to a valid result
    a_last_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dp_cmd.step && w_stat.last_step) |=> o_valid)
        else $error("walk ended without a result");

endmodule

[hw/rtl/msl_ram.sv]
// msl_ram: generic single write port, single read port ram with
// registered read data; no dependencies
`timescale 1ns / 1ps

module msl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/msl_ctrl.sv]
// msl_ctrl: controller state machine for the median block
// depends on msl_pkg
`timescale 1ns / 1ps

module msl_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [msl_pkg::CMD_W-1:0] i_cmd,
    output logic                      o_stall,
    output logic                      o_valid,
    input  logic                      i_stall,
    input  msl_pkg::t_stat            i_stat,
    output msl_pkg::t_cmd             o_dp_cmd
);

    import msl_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_free;
    logic       w_accept;

    // input side is open when idle or when the held result leaves now
    assign w_free   = (r_state == S_IDLE) || ((r_state == S_OUT) && !i_stall);
    assign w_accept = i_valid && w_free;
    assign o_stall  = !w_free;
    assign o_valid  = (r_state == S_OUT);

    // next state and datapath commands
    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        case (r_state)
            S_IDLE, S_OUT: begin
                if (r_state == S_OUT && !i_stall) begin
                    n_state = S_IDLE;
                end
                if (w_accept) begin
                    case (i_cmd)
                        CMD_LOAD_FIRST:  o_dp_cmd.load_first  = 1'b1;
                        CMD_LOAD_SECOND: o_dp_cmd.load_second = 1'b1;
                        CMD_COMPUTE: begin
                            o_dp_cmd.start = 1'b1;
                            n_state = i_stat.set_empty ? S_OUT : S_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                o_dp_cmd.step = 1'b1;
                if (i_stat.last_step) begin
                    n_state = S_OUT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hw/rtl/msl_dp.sv]
// msl_dp: datapath with both list memories, counts and the merge walk
// depends on msl_pkg and msl_ram
`timescale 1ns / 1ps

module msl_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  msl_pkg::t_cmd                     i_dp_cmd,
    input  logic signed [msl_pkg::DATA_W-1:0] i_value,
    output msl_pkg::t_stat                    o_stat,
    output logic signed [msl_pkg::RES_W-1:0]  o_twice_median,
    output logic                              o_empty_set,
    output logic                              o_dropped
);

    import msl_pkg::*;

    logic [CNT_W-1:0]          r_cnt1, r_cnt2;
    logic                      r_ovf;
    logic [CNT_W-1:0]          r_lim1, r_lim2;
    logic [CNT_W-1:0]          r_i, r_j, r_k;
    logic [CNT_W-1:0]          n_i, n_j;
    logic [CNT_W-1:0]          r_lo_pos, r_hi_pos;
    logic signed [DATA_W-1:0]  r_lo;
    logic signed [RES_W-1:0]   r_twice_median;
    logic                      r_empty_set;
    logic                      r_dropped;
    logic [DATA_W-1:0]         w_rd1, w_rd2;
    logic signed [DATA_W-1:0]  w_a, w_b, w_pick, w_lo_sel;
    logic                      w_has1, w_has2, w_take1;
    logic [TOT_W-1:0]          w_total, w_total_m1;
    logic signed [RES_W-1:0]   w_sum;
    logic                      w_full1, w_full2;

    // list memories, read address follows the walk pointers
    msl_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_ram_first (
        .i_clk   (i_clk),
        .i_we    (i_dp_cmd.load_first && !w_full1),
        .i_waddr (r_cnt1[ADDR_W-1:0]),
        .i_wdata (i_value),
        .i_raddr (n_i[ADDR_W-1:0]),
        .o_rdata (w_rd1)
    );

    msl_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_ram_second (
        .i_clk   (i_clk),
        .i_we    (i_dp_cmd.load_second && !w_full2),
        .i_waddr (r_cnt2[ADDR_W-1:0]),
        .i_wdata (i_value),
        .i_raddr (n_j[ADDR_W-1:0]),
        .o_rdata (w_rd2)
    );

    assign w_full1 = (r_cnt1 == CNT_W'(MAX_LEN));
    assign w_full2 = (r_cnt2 == CNT_W'(MAX_LEN));

    // combined length and one less, halved below into the middle positions
    assign w_total    = {1'b0, r_cnt1} + {1'b0, r_cnt2};
    assign w_total_m1 = w_total - TOT_W'(1);

    // one merge step: pick the smaller head, first list on ties
    assign w_a      = $signed(w_rd1);
    assign w_b      = $signed(w_rd2);
    assign w_has1   = (r_i < r_lim1);
    assign w_has2   = (r_j < r_lim2);
    assign w_take1  = (w_has1 && w_has2) ? (w_a <= w_b) : w_has1;
    assign w_pick   = w_take1 ? w_a : w_b;
    assign w_lo_sel = (r_k == r_lo_pos) ? w_pick : r_lo;
    assign w_sum    = {w_lo_sel[DATA_W-1], w_lo_sel} + {w_pick[DATA_W-1], w_pick};

    assign o_stat.set_empty = (r_cnt1 == '0) && (r_cnt2 == '0);
    assign o_stat.last_step = (r_k == r_hi_pos);

    // walk pointers return to zero after the last step
    always_comb begin
        n_i = r_i;
        n_j = r_j;
        if (i_dp_cmd.step) begin
            if (o_stat.last_step) begin
                n_i = '0;
                n_j = '0;
            end else if (w_take1) begin
                n_i = r_i + CNT_W'(1);
            end else begin
                n_j = r_j + CNT_W'(1);
            end
        end
    end

    // counts, overflow flag and walk pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt1 <= '0;
            r_cnt2 <= '0;
            r_ovf  <= 1'b0;
            r_i    <= '0;
            r_j    <= '0;
        end else begin
            r_i <= n_i;
            r_j <= n_j;
            if (i_dp_cmd.start) begin
                r_cnt1 <= '0;
                r_cnt2 <= '0;
                r_ovf  <= 1'b0;
            end else if (i_dp_cmd.load_first) begin
                if (w_full1) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_cnt1 <= r_cnt1 + CNT_W'(1);
                end
            end else if (i_dp_cmd.load_second) begin
                if (w_full2) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_cnt2 <= r_cnt2 + CNT_W'(1);
                end
            end
        end
    end

    // walk limits, step counter and result word
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.start) begin
            r_lim1      <= r_cnt1;
            r_lim2      <= r_cnt2;
            r_k         <= '0;
            r_lo_pos    <= w_total_m1[CNT_W:1];
            r_hi_pos    <= w_total[CNT_W:1];
            r_dropped   <= r_ovf;
            r_empty_set <= o_stat.set_empty;
            if (o_stat.set_empty) begin
                r_twice_median <= '0;
            end
        end else if (i_dp_cmd.step) begin
            r_k <= r_k + CNT_W'(1);
            if (r_k == r_lo_pos) begin
                r_lo <= w_pick;
            end
            if (o_stat.last_step) begin
                r_twice_median <= w_sum;
            end
        end
    end

    assign o_twice_median = r_twice_median;
    assign o_empty_set    = r_empty_set;
    assign o_dropped      = r_dropped;

endmodule

[dv/tb_median_of_two_sorted_lists.sv]
// tb_median_of_two_sorted_lists: self-checking testbench for the two-list median block
// depends on msl_pkg and median_of_two_sorted_lists; holds its own merge-walk predictor
`timescale 1ns / 1ps

module tb_median_of_two_sorted_lists;
    import msl_pkg::*;

    // command code the block ignores
    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

    // value styles for generated lists
    localparam int unsigned VAL_WIDE    = 0;
    localparam int unsigned VAL_NARROW  = 1;
    localparam int unsigned VAL_EXTREME = 2;
    localparam int unsigned VAL_MIXED   = 3;

    localparam int VAL_MAX = 2147483647;
    localparam int VAL_MIN = -2147483647 - 1;

    // longest quiet stretch: full-size walk, long receiver hold, worst gaps
    localparam int unsigned QUIET_LIMIT   = 5000;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned RANDOM_WORDS  = 600;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [RES_W-1:0] twice_median;
        logic             empty_set;
        logic             dropped;
    } t_median_word;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [CMD_W-1:0]         i_cmd;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [RES_W-1:0]  o_twice_median;
    logic                     o_empty_set;
    logic                     o_dropped;

    // predictor state
    int           first_list_q[$];
    int           second_list_q[$];
    bit           loads_dropped;
    t_median_word expected_medians[$];

    int unsigned words_accepted = 0;
    int unsigned mismatch_count = 0;
    int unsigned tx_max_gap     = 8;
    int unsigned rx_max_stall   = 8;
    int unsigned rx_hold_len    = 0;

    median_of_two_sorted_lists u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_twice_median (o_twice_median),
        .o_empty_set    (o_empty_set),
        .o_dropped      (o_dropped)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // merge-walk both lists to the middle, sum the two middle picks
    function automatic t_median_word take_median();
        t_median_word        res;
        int unsigned         total;
        int unsigned         lo_pos;
        int unsigned         hi_pos;
        int unsigned         ia;
        int unsigned         ib;
        longint              lo;
        longint              hi;
        longint              pick;
        logic signed [63:0]  sum_wide;
        bit                  from_first;
        total = first_list_q.size() + second_list_q.size();
        lo = 0;
        hi = 0;
        ia = 0;
        ib = 0;
        if (total != 0) begin
            lo_pos = (total - 1) / 2;
            hi_pos = total / 2;
            for (int unsigned k = 0; k <= hi_pos; k++) begin
                if (ia < first_list_q.size() && ib < second_list_q.size())
                    from_first = (first_list_q[ia] <= second_list_q[ib]);
                else
                    from_first = (ia < first_list_q.size());
                if (from_first) begin
                    pick = longint'(first_list_q[ia]);
                    ia++;
                end else begin
                    pick = longint'(second_list_q[ib]);
                    ib++;
                end
                if (k == lo_pos)
                    lo = pick;
                if (k == hi_pos)
                    hi = pick;
            end
        end
        sum_wide         = lo + hi;
        res.twice_median = sum_wide[RES_W-1:0];
        res.empty_set    = (total == 0);
        res.dropped      = loads_dropped;
        return res;
    endfunction

    // update predictor with one accepted word
    function automatic void absorb_word(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value);
        case (cmd)
            CMD_LOAD_FIRST: begin
                if (first_list_q.size() < MAX_LEN)
                    first_list_q.insert(first_list_q.size(), int'(value));
                else
                    loads_dropped = 1'b1;
            end
            CMD_LOAD_SECOND: begin
                if (second_list_q.size() < MAX_LEN)
                    second_list_q.insert(second_list_q.size(), int'(value));
                else
                    loads_dropped = 1'b1;
            end
            CMD_COMPUTE: begin
                expected_medians.insert(expected_medians.size(), take_median());
                first_list_q.delete();
                second_list_q.delete();
                loads_dropped = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // offer one word after a random gap, hold it until taken
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
        int unsigned gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        absorb_word(cmd, value);
        if (cmd != CMD_IGNORED)
            words_accepted++;
    endtask

    // sender pause until every pending result is back
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_medians.size() != 0);
    endtask

    function automatic int draw_value(int unsigned style);
        int unsigned pick_style;
        pick_style = (style == VAL_MIXED) ? $urandom_range(VAL_WIDE, VAL_EXTREME) : style;
        case (pick_style)
            VAL_NARROW: return int'($urandom_range(0, 8)) - 4;
            VAL_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: return VAL_MIN + int'($urandom_range(0, 3));
                    1: return VAL_MAX - int'($urandom_range(0, 3));
                    2: return -1;
                    default: return 0;
                endcase
            end
            default: return int'($urandom);
        endcase
    endfunction

    function automatic void fill_list(ref int vals[$], input int unsigned len,
                                      input int unsigned style, input bit ordered);
        vals.delete();
        repeat (len) vals.insert(vals.size(), draw_value(style));
        if (ordered)
            vals.sort();
    endfunction

    // mostly short lists, a few long ones
    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        else if (r < 75)
            return $urandom_range(1, 8);
        else if (r < 95)
            return $urandom_range(9, 40);
        else
            return $urandom_range(41, 200);
    endfunction

    function automatic int unsigned pick_idle_max();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 3;
            default: return 8;
        endcase
    endfunction

    // load both lists in random interleave, with optional ignored words, then ask for the median
    task automatic run_set(input int first_part[$], input int second_part[$],
                           input bit with_noise);
        int unsigned ia;
        int unsigned ib;
        ia = 0;
        ib = 0;
        while (ia < first_part.size() || ib < second_part.size()) begin
            if (ib >= second_part.size() ||
                (ia < first_part.size() && $urandom_range(0, 1) == 1)) begin
                send_word(CMD_LOAD_FIRST, first_part[ia]);
                ia++;
            end else begin
                send_word(CMD_LOAD_SECOND, second_part[ib]);
                ib++;
            end
            if (with_noise && $urandom_range(0, 39) == 0)
                send_word(CMD_IGNORED, $urandom);
        end
        if (with_noise && $urandom_range(0, 19) == 0)
            send_word(CMD_IGNORED, $urandom);
        send_word(CMD_COMPUTE, $urandom);
    endtask

    // field extremes, empty set, sum overflow, ignored command, unsorted walk
    task automatic test_directed_cases();
        send_word(CMD_COMPUTE, $urandom);
        send_word(CMD_LOAD_FIRST, VAL_MAX);
        send_word(CMD_COMPUTE, 32'hffff_ffff);
        send_word(CMD_LOAD_SECOND, VAL_MIN);
        send_word(CMD_COMPUTE, 32'h0);
        send_word(CMD_LOAD_FIRST, VAL_MAX);
        send_word(CMD_LOAD_SECOND, VAL_MAX);
        send_word(CMD_COMPUTE, $urandom);
        send_word(CMD_LOAD_SECOND, VAL_MIN);
        send_word(CMD_LOAD_FIRST, VAL_MIN);
        send_word(CMD_COMPUTE, $urandom);
        send_word(CMD_LOAD_FIRST, VAL_MIN);
        send_word(CMD_LOAD_SECOND, VAL_MAX);
        send_word(CMD_COMPUTE, $urandom);
        send_word(CMD_LOAD_FIRST, -1);
        send_word(CMD_IGNORED, 32'hffff_ffff);
        send_word(CMD_LOAD_FIRST, 0);
        send_word(CMD_LOAD_SECOND, 1);
        send_word(CMD_COMPUTE, $urandom);
        send_word(CMD_LOAD_SECOND, -5);
        send_word(CMD_LOAD_SECOND, 3);
        send_word(CMD_LOAD_SECOND, 7);
        send_word(CMD_LOAD_SECOND, 9);
        send_word(CMD_COMPUTE, $urandom);
        // unsorted first list still follows the merge rule
        send_word(CMD_LOAD_FIRST, 5);
        send_word(CMD_LOAD_FIRST, -3);
        send_word(CMD_LOAD_SECOND, 0);
        send_word(CMD_COMPUTE, $urandom);
        wait_results_drained();
    endtask

    // full first list, dropped loads, long walk
    task automatic test_list_capacity();
        int a[$];
        int b[$];
        tx_max_gap = 1;
        fill_list(a, MAX_LEN, VAL_MIXED, 1'b1);
        a.insert(a.size(), draw_value(VAL_WIDE));
        a.insert(a.size(), draw_value(VAL_WIDE));
        fill_list(b, 2, VAL_WIDE, 1'b1);
        run_set(a, b, 1'b0);
        // flag must be clear on the next set
        fill_list(a, 3, VAL_NARROW, 1'b1);
        fill_list(b, 0, VAL_NARROW, 1'b1);
        run_set(a, b, 1'b0);
        wait_results_drained();
        tx_max_gap = 8;
    endtask

    // receiver holds off while the sender keeps offering computes
    task automatic test_backpressure();
        int a[$];
        int b[$];
        tx_max_gap   = 0;
        rx_max_stall = 0;
        rx_hold_len  = LONG_HOLD;
        repeat (12) begin
            fill_list(a, $urandom_range(0, 2), VAL_WIDE, 1'b1);
            fill_list(b, $urandom_range(0, 2), VAL_WIDE, 1'b1);
            run_set(a, b, 1'b0);
        end
        wait_results_drained();
        tx_max_gap   = 8;
        rx_max_stall = 8;
    endtask

    // mostly sorted sets with random content, some unsorted, some noise
    task automatic test_random_sets();
        int a[$];
        int b[$];
        int unsigned goal;
        int unsigned set_idx;
        int unsigned style;
        bit          ordered;
        goal    = words_accepted + RANDOM_WORDS;
        set_idx = 0;
        while (words_accepted < goal) begin
            if (set_idx % 16 == 0) begin
                tx_max_gap   = pick_idle_max();
                rx_max_stall = pick_idle_max();
            end
            style   = $urandom_range(VAL_WIDE, VAL_MIXED);
            ordered = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 24) == 0) begin
                a.delete();
                b.delete();
            end else begin
                fill_list(a, pick_len(), style, ordered);
                fill_list(b, pick_len(), style, ordered);
            end
            run_set(a, b, 1'b1);
            if ($urandom_range(0, 29) == 0)
                wait_results_drained();
            set_idx++;
        end
        wait_results_drained();
    endtask

    // result side: random stall per word, one long hold on request
    initial begin : result_sink
        int unsigned pause;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_len != 0) begin
                pause       = rx_hold_len;
                rx_hold_len = 0;
            end else begin
                pause = $urandom_range(0, rx_max_stall);
            end
            if (pause != 0) begin
                i_stall <= 1'b1;
                repeat (pause) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
        end
    end

    // compare each taken result word with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_median_word want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_medians.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result word: twice_median %0d empty %0b dropped %0b",
                             o_twice_median, o_empty_set, o_dropped);
            end else begin
                want = expected_medians.pop_front();
                if (o_twice_median !== want.twice_median || o_empty_set !== want.empty_set ||
                    o_dropped !== want.dropped) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"mismatch: expected twice_median %0d empty %0b dropped %0b,",
                                  " got %0d %0b %0b"},
                                 $signed(want.twice_median), want.empty_set, want.dropped,
                                 o_twice_median, o_empty_set, o_dropped);
                end
            end
        end
    end

    // end the run when no word moves on either side for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= QUIET_LIMIT) begin
                    $display("[median_of_two_sorted_lists] ERROR");
                    $finish;
                end
            end
        end
    end

    // main sequence
    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_cmd         <= CMD_LOAD_FIRST;
        i_value       <= '0;
        loads_dropped = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_list_capacity();
        test_backpressure();
        test_random_sets();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_medians.size() == 0)
            $display("[median_of_two_sorted_lists] OK");
        else
            $display("[median_of_two_sorted_lists] ERROR");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/msl_pkg.sv
hw/rtl/msl_ram.sv
hw/rtl/msl_ctrl.sv
hw/rtl/msl_dp.sv
hw/rtl/median_of_two_sorted_lists.sv
dv/tb_median_of_two_sorted_lists.sv
